// ===== sv/sitda_pkg.sv =====
package sitda_pkg;

	localparam int unsigned ValueW  = 32;
	localparam int unsigned MagW    = 32;
	localparam int unsigned NDigits = 10;
	localparam int unsigned BcdW    = 4 * NDigits;
	localparam int unsigned CntW    = 4;
	// bits converted per pipeline stage of the double-dabble unit
	localparam int unsigned BitsPerStage = 4;
	localparam int unsigned NStages      = MagW / BitsPerStage;

	localparam logic [7:0] CharZero  = 8'd48;
	localparam logic [7:0] CharMinus = 8'd45;

	typedef struct packed {
		logic            neg;
		logic [MagW-1:0] mag;
		logic [BcdW-1:0] bcd;
	} dd_work_t;

	typedef struct packed {
		logic            neg;
		logic [BcdW-1:0] bcd;
		logic [CntW-1:0] nd;
	} conv_res_t;

	// one shift-add-3 step: correct each BCD digit, then shift in a magnitude bit
	function automatic logic [BcdW-1:0] dabble(input logic [BcdW-1:0] bcd, input logic in_bit);
		logic [BcdW-1:0] adj;
		adj = bcd;
		for (int i = 0; i < NDigits; i++) begin
			if (adj[4*i +: 4] > 4'd4) begin
				adj[4*i +: 4] = adj[4*i +: 4] + 4'd3;
			end
		end
		return {adj[BcdW-2:0], in_bit};
	endfunction

endpackage

// ===== sv/sitda_stage.sv =====
// One stage of the binary to BCD pipeline: BitsPerStage dabble steps
module sitda_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  sitda_pkg::dd_work_t in_data,
	output logic               in_ready,
	output logic               out_valid,
	output sitda_pkg::dd_work_t out_data,
	input  logic               out_ready
);
	sitda_pkg::dd_work_t nxt;
	logic                valid_s1;
	sitda_pkg::dd_work_t data_s1;

	// advance the work word by BitsPerStage bits
	always_comb begin
		nxt = in_data;
		for (int i = 0; i < sitda_pkg::BitsPerStage; i++) begin
			nxt.bcd = sitda_pkg::dabble(nxt.bcd, nxt.mag[sitda_pkg::MagW-1]);
			nxt.mag = {nxt.mag[sitda_pkg::MagW-2:0], 1'b0};
		end
	end

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_data  = data_s1;

	// hold on stall, load on accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= nxt;
		end
	end
endmodule

// ===== sv/sitda_conv.sv =====
// Sign strip, double-dabble pipeline, digit count
module sitda_conv (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [31:0]        value,
	output logic                      out_valid,
	input  logic                      out_ready,
	output sitda_pkg::conv_res_t      out_data
);
	localparam int unsigned N = sitda_pkg::NStages;

	logic                v   [N+1];
	logic                r   [N+1];
	sitda_pkg::dd_work_t d   [N+1];
	logic                valid_s1;
	sitda_pkg::conv_res_t data_s1;
	logic                ld;
	logic [sitda_pkg::CntW-1:0] cnt;

	// take the magnitude; the most negative value wraps to itself, exact as unsigned
	assign v[0]       = in_valid;
	assign in_ready   = r[0];
	assign d[0].neg   = value[31];
	assign d[0].mag   = value[31] ? (32'd0 - $unsigned(value)) : $unsigned(value);
	assign d[0].bcd   = '0;

	for (genvar g = 0; g < N; g++) begin : g_st
		sitda_stage u_st (
			.clk(clk), .arst_n(arst_n),
			.in_valid(v[g]), .in_data(d[g]), .in_ready(r[g]),
			.out_valid(v[g+1]), .out_data(d[g+1]), .out_ready(r[g+1])
		);
	end

	// count significant digits: highest nonzero digit plus one, at least one
	always_comb begin
		cnt = sitda_pkg::CntW'(1);
		for (int i = 1; i < sitda_pkg::NDigits; i++) begin
			if (d[N].bcd[4*i +: 4] != 4'd0) begin
				cnt = sitda_pkg::CntW'(i + 1);
			end
		end
	end

	assign r[N] = !valid_s1 || out_ready;
	assign ld   = r[N] && v[N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (r[N]) begin
			valid_s1 <= v[N];
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			data_s1.neg <= d[N].neg;
			data_s1.bcd <= d[N].bcd;
			data_s1.nd  <= cnt;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;
endmodule

// ===== sv/sitda_emit.sv =====
// Serialize one converted number into characters
module sitda_emit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  sitda_pkg::conv_res_t in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           char_code,
	output logic                 last_char
);
	logic                       busy_q;
	logic                       sign_q;
	logic [sitda_pkg::BcdW-1:0] bcd_q;
	logic [sitda_pkg::CntW-1:0] idx_q;
	logic [3:0]                 dig;
	logic                       fire;

	// pick the current digit; idx_q counts remaining digits, top one is idx_q-1
	always_comb begin
		dig = 4'd0;
		for (int i = 0; i < sitda_pkg::NDigits; i++) begin
			if (idx_q == sitda_pkg::CntW'(i + 1)) begin
				dig = bcd_q[4*i +: 4];
			end
		end
	end

	assign out_valid = busy_q;
	assign char_code = sign_q ? sitda_pkg::CharMinus : (sitda_pkg::CharZero + {4'd0, dig});
	assign last_char = !sign_q && (idx_q == sitda_pkg::CntW'(1));
	assign fire      = busy_q && out_ready;
	assign in_ready  = !busy_q || (fire && last_char);

	// load a number, drop the sign beat, then step down through the digits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			sign_q <= 1'b0;
			idx_q  <= '0;
		end else if (in_ready && in_valid) begin
			busy_q <= 1'b1;
			sign_q <= in_data.neg;
			idx_q  <= in_data.nd;
		end else if (fire) begin
			if (last_char) begin
				busy_q <= 1'b0;
			end else if (sign_q) begin
				sign_q <= 1'b0;
			end else begin
				idx_q <= idx_q - sitda_pkg::CntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			bcd_q <= in_data.bcd;
		end
	end

`ifndef ASSERT_OFF
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (idx_q != '0 && idx_q <= sitda_pkg::CntW'(sitda_pkg::NDigits)))
		else $error("digit index out of range");
	a_digit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !sign_q) |-> (dig <= 4'd9))
		else $error("non-decimal digit");
	a_sign_first: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && sign_q) |=> (busy_q && !sign_q))
		else $error("sign beat not followed by digits");
`endif
endmodule

// ===== sv/signed_int_to_decimal_ascii.sv =====
// Converts a signed 32-bit integer to its decimal ASCII text, most significant
// character first, with a leading '-' for negative values and no leading zeros;
// the final character of each number has last_char set. An input beat passes
// through an eight-stage double-dabble pipeline (four bits per stage) plus one
// count stage, each registered; the character serializer then sends one
// character per cycle while out_ready is high, 1 to 11 per number, and loads
// the next number as the last character of the current one is taken.
module signed_int_to_decimal_ascii (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         char_code,
	output logic               last_char
);
	logic                 cv;
	logic                 cr;
	sitda_pkg::conv_res_t cd;

	sitda_conv u_conv (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .value(value),
		.out_valid(cv), .out_ready(cr), .out_data(cd)
	);

	sitda_emit u_emit (
		.clk(clk), .arst_n(arst_n),
		.in_valid(cv), .in_ready(cr), .in_data(cd),
		.out_valid(out_valid), .out_ready(out_ready),
		.char_code(char_code), .last_char(last_char)
	);
endmodule

// ===== tb/sv/itoa_text_checker.sv =====
`timescale 1ns / 100ps

module itoa_text_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic signed [31:0] value,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [7:0]         char_code,
	input  logic               last_char,
	output int                 fail_count,
	output int                 pending_chars,
	output int                 numbers_seen,
	output int                 chars_seen
);
	typedef struct packed {
		logic [7:0] code;
		logic       last;
	} text_char_t;

	text_char_t expected_text[$];

	// append the decimal text of one number to the expected characters
	task automatic queue_decimal_text(input logic [31:0] raw);
		logic [31:0] mag;
		logic [3:0]  digit[10];
		int          nd;
		int          total;
		int          k;
		text_char_t  c;
		mag = raw[31] ? (32'd0 - raw) : raw;
		nd = 0;
		do begin
			digit[nd] = 4'(mag % 32'd10);
			mag = mag / 32'd10;
			nd++;
		end while (mag != 0 && nd < 10);
		total = nd + (raw[31] ? 1 : 0);
		k = 0;
		if (raw[31]) begin
			c.code = sitda_pkg::CharMinus;
			c.last = (k == total - 1);
			expected_text.push_back(c);
			k++;
		end
		for (int d = nd - 1; d >= 0; d--) begin
			c.code = sitda_pkg::CharZero + 8'(digit[d]);
			c.last = (k == total - 1);
			expected_text.push_back(c);
			k++;
		end
	endtask

	task automatic report_mismatch(input string what);
		$display("%0t: mismatch: %s", $realtime, what);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		pending_chars = 0;
		numbers_seen = 0;
		chars_seen = 0;
	end

	// predict on input beats, compare on output beats
	always @(posedge clk) begin
		text_char_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				queue_decimal_text(value);
				numbers_seen++;
			end
			if (out_valid && out_ready) begin
				chars_seen++;
				if (expected_text.size() == 0) begin
					report_mismatch($sformatf("unexpected char %0d", char_code));
				end else begin
					want = expected_text.pop_front();
					if (char_code !== want.code)
						report_mismatch($sformatf("char_code %0d, want %0d", char_code, want.code));
					if (last_char !== want.last)
						report_mismatch($sformatf("last_char %b, want %b", last_char, want.last));
				end
			end
		end
		pending_chars = expected_text.size();
	end
endmodule

// ===== tb/sv/tb_signed_int_to_decimal_ascii.sv =====
`timescale 1ns / 100ps

module tb_signed_int_to_decimal_ascii;
	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic signed [31:0] value;
	logic               out_valid;
	logic               out_ready;
	logic [7:0]         char_code;
	logic               last_char;
	int                 fail_count;
	int                 pending_chars;
	int                 numbers_seen;
	int                 chars_seen;
	int                 send_idle_pct;
	int                 recv_idle_pct;

	signed_int_to_decimal_ascii dut (.*);

	itoa_text_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// receiver stalls at random
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// hold one beat until accepted; valid drops only on an idle cycle
	task automatic send_number(input logic [31:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		value <= v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// mostly varied magnitudes so every digit count shows up
	function automatic logic [31:0] random_number();
		logic [31:0] v;
		int          sh;
		v = $urandom;
		case ($urandom_range(5))
			0: ;
			1: begin
				sh = $urandom_range(31);
				v = v >> sh;
			end
			2: v = 32'd0 - (v >> $urandom_range(31));
			3: v = $urandom_range(20);
			4: v = 32'd0 - 32'($urandom_range(20));
			default: v = 32'd1 * (10 ** $urandom_range(9)) - 32'($urandom_range(1));
		endcase
		return v;
	endfunction

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_chars != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	initial begin
		logic [31:0] directed[$];
		arst_n = 1'b0;
		in_valid = 1'b0;
		value = '0;
		out_ready = 1'b0;
		send_idle_pct = 13;
		recv_idle_pct = 81;
		directed = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, 32'hFFFF_FFF6,
			32'd99, 32'd100, 32'd1000000000, 32'd999999999, 32'd4294967295,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'hAAAA_AAAA,
			32'h5555_5555, 32'd123456789, 32'hF8A4_32EB};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) send_number(directed[i]);
		// hold off until every character is out
		wait_drained();

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 81 : 0;
			recv_idle_pct = (phase == 0) ? 81 : (phase == 1) ? 13 : 0;
			repeat (100) send_number(random_number());
		end
		wait_drained();

		$display("converted %0d numbers into %0d characters", numbers_seen, chars_seen);
		$display("covered zero, both extremes, every digit count, both signs");
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end
endmodule
